// ----- hdl/skil_pkg.sv -----
// Shared types, constants and helper functions for the sampled k-mer index lookup block.
// Depends on nothing; skil_dp, skil_ctrl and the top level refer to it by scoped names.
`timescale 1ns / 1ps

package skil_pkg;

  // Default sizing, handed to the top level as parameter defaults.
  localparam int ENTRY_DEPTH      = 65536;
  localparam int MAX_PREFIX_BASES = 8;
  localparam int MAX_KMER_BASES   = 31;

  // Fixed field widths of the streaming and configuration ports.
  localparam int KMER_CODE_W   = 62;
  localparam int ENTRY_INDEX_W = 16;
  localparam int KMER_LEN_W    = 5;
  localparam int PREFIX_LEN_W  = 4;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 5;

  localparam logic [KMER_LEN_W-1:0]   KMER_LEN_RESET   = 5'd31;
  localparam logic [PREFIX_LEN_W-1:0] PREFIX_LEN_RESET = 4'd4;

  typedef enum logic [1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_LOAD     = 2'd1,
    CMD_FINALIZE = 2'd2,
    CMD_QUERY    = 2'd3
  } cmd_code_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_MISS      = 3'd1,
    STAT_UNSAMPLED = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_ORDER     = 3'd4,
    STAT_NOT_FIN   = 3'd5
  } status_code_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KMER_LENGTH   = 1'b0,
    REG_PREFIX_LENGTH = 1'b1
  } cfg_reg_t;

  // Sampling rule: the code is sampled when any residue hits its target.
  localparam int NUM_MODULI = 5;
  localparam int RES_W      = 7;
  localparam logic [NUM_MODULI-1:0][RES_W-1:0] MODULUS =
    {7'd71, 7'd53, 7'd19, 7'd17, 7'd7};
  localparam logic [NUM_MODULI-1:0][RES_W-1:0] RESIDUE_HIT =
    {7'd47, 7'd31, 7'd13, 7'd7, 7'd5};

  // One four-bit digit of a most-significant-first residue computation.
  // The running value stays below sixteen times the modulus, so four
  // compare-and-subtract steps bring it back into range.
  function automatic logic [RES_W-1:0] mod_step(input logic [RES_W-1:0] r,
                                                input logic [3:0]       d,
                                                input logic [RES_W-1:0] m);
    logic [RES_W+3:0] t;
    t = {r, d};
    if (t >= (RES_W+4)'({m, 3'b000})) t = t - (RES_W+4)'({m, 3'b000});
    if (t >= (RES_W+4)'({m, 2'b00}))  t = t - (RES_W+4)'({m, 2'b00});
    if (t >= (RES_W+4)'({m, 1'b0}))   t = t - (RES_W+4)'({m, 1'b0});
    if (t >= (RES_W+4)'(m))           t = t - (RES_W+4)'(m);
    return t[RES_W-1:0];
  endfunction

  typedef enum logic [1:0] {
    BT_RD_SWEEP  = 2'd0,
    BT_RD_BUCKET = 2'd1,
    BT_RD_PREV   = 2'd2
  } bt_rd_sel_t;

  typedef enum logic [1:0] {
    IDX_ZERO  = 2'd0,
    IDX_COUNT = 2'd1,
    IDX_MID   = 2'd2
  } idx_sel_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_RES,
    S_DECIDE,
    S_CLR,
    S_FIN,
    S_LD_RD,
    S_LD_WR,
    S_Q_END,
    S_Q_BEG,
    S_Q_BND,
    S_S_ADDR,
    S_S_CMP,
    S_RESP
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         accept;
    logic         res_step;
    logic         clr_step;
    logic         fin_step;
    logic         fin_done;
    logic         clear_state;
    bt_rd_sel_t   bt_rd_sel;
    logic         ld_commit;
    logic         q_latch_end;
    logic         q_bounds;
    logic         srch_issue;
    logic         srch_lo_up;
    logic         srch_hi_down;
    logic         res_set;
    status_code_t res_status;
    idx_sel_t     res_idx;
    logic         out_push;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    cmd_code_t cmd;
    logic      res_last;
    logic      sampled;
    logic      finalized;
    logic      order_bad;
    logic      full;
    logic      sweep_last;
    logic      fin_last;
    logic      srch_empty;
    logic      cmp_eq;
    logic      cmp_gt;
    logic      out_free;
  } dp_sts_t;

endpackage

// ----- hdl/skil_ram.sv -----
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module skil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hdl/skil_dp.sv -----
// Datapath of the k-mer index: configuration, residue unit, entry and bucket memories,
// search bounds and result register. Depends on skil_pkg and skil_ram.
`timescale 1ns / 1ps

module skil_dp #(
  parameter int ENTRY_DEPTH      = skil_pkg::ENTRY_DEPTH,
  parameter int MAX_PREFIX_BASES = skil_pkg::MAX_PREFIX_BASES,
  parameter int MAX_KMER_BASES   = skil_pkg::MAX_KMER_BASES
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic [skil_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [skil_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  skil_pkg::cmd_code_t                  in_command,
  input  logic [skil_pkg::KMER_CODE_W-1:0]     in_kmer_code,
  input  skil_pkg::dp_cmd_t                    cmd,
  output skil_pkg::dp_sts_t                    sts,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output skil_pkg::status_code_t               out_status,
  output logic                                 out_found,
  output logic [skil_pkg::ENTRY_INDEX_W-1:0]   out_entry_index
);

  localparam int CW        = 2 * MAX_KMER_BASES;
  localparam int AW        = $clog2(ENTRY_DEPTH);
  localparam int CNT_W     = AW + 1;
  localparam int BW        = 2 * MAX_PREFIX_BASES;
  localparam int NB        = 1 << BW;
  localparam int XW        = (CW > BW) ? CW : BW;
  localparam int RES_STEPS = (CW + 3) / 4;
  localparam int PW        = 4 * RES_STEPS;
  localparam int RC_W      = (RES_STEPS > 1) ? $clog2(RES_STEPS) : 1;
  localparam int KW        = skil_pkg::KMER_LEN_W;
  localparam int RW        = skil_pkg::RES_W;

  // Configuration registers.
  logic [KW-1:0]                     kmer_length;
  logic [skil_pkg::PREFIX_LEN_W-1:0] prefix_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length   <= skil_pkg::KMER_LEN_RESET;
      prefix_length <= skil_pkg::PREFIX_LEN_RESET;
    end else if (cfg_valid) begin
      unique case (skil_pkg::cfg_reg_t'(cfg_index))
        skil_pkg::REG_KMER_LENGTH:   kmer_length   <= cfg_data[KW-1:0];
        skil_pkg::REG_PREFIX_LENGTH: prefix_length <= cfg_data[skil_pkg::PREFIX_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective lengths, input masking and bucket selection.
  logic [KW-1:0] k_eff;
  logic [KW-1:0] p_eff;
  logic [CW-1:0] code_m;
  logic [XW-1:0] code_x;
  logic [XW-1:0] bucket_x;
  logic [5:0]    shamt;

  always_comb begin
    k_eff = kmer_length;
    if (k_eff == '0) k_eff = KW'(1);
    if (k_eff > KW'(MAX_KMER_BASES)) k_eff = KW'(MAX_KMER_BASES);
    p_eff = KW'(prefix_length);
    if (p_eff == '0) p_eff = KW'(1);
    if (p_eff > KW'(MAX_PREFIX_BASES)) p_eff = KW'(MAX_PREFIX_BASES);
    if (p_eff > k_eff) p_eff = k_eff;
    for (int i = 0; i < CW; i++) begin
      code_m[i] = in_kmer_code[i] & (6'(i) < {k_eff, 1'b0});
    end
    code_x   = XW'(code_m);
    shamt    = {k_eff - p_eff, 1'b0};
    bucket_x = code_x >> shamt;
  end

  // Item registers and residue unit.
  skil_pkg::cmd_code_t                        cmd_r;
  logic [CW-1:0]                              code_r;
  logic [BW-1:0]                              bucket_r;
  logic [PW-1:0]                              code_sh;
  logic [RC_W-1:0]                            res_cnt;
  logic [skil_pkg::NUM_MODULI-1:0][RW-1:0]    res_r;
  logic                                       sampled;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r    <= in_command;
      code_r   <= code_m;
      bucket_r <= bucket_x[BW-1:0];
      code_sh  <= PW'(code_m);
      res_cnt  <= '0;
      res_r    <= '0;
    end else if (cmd.res_step) begin
      for (int j = 0; j < skil_pkg::NUM_MODULI; j++) begin
        res_r[j] <= skil_pkg::mod_step(res_r[j], code_sh[PW-1 -: 4], skil_pkg::MODULUS[j]);
      end
      code_sh <= code_sh << 4;
      res_cnt <= res_cnt + RC_W'(1);
    end
  end

  always_comb begin
    sampled = 1'b0;
    for (int j = 0; j < skil_pkg::NUM_MODULI; j++) begin
      sampled = sampled | (res_r[j] == skil_pkg::RESIDUE_HIT[j]);
    end
  end

  // Index state.
  logic [CNT_W-1:0] count_r;
  logic [CW-1:0]    last_r;
  logic             fin_r;

  // Sweep counter and running sum for clearing and finalizing the bucket table.
  logic [BW:0]      sweep_r;
  logic [CNT_W-1:0] sum_r;
  logic [CNT_W-1:0] sum_next;

  // Bucket table memory.
  logic             bt_we;
  logic [BW-1:0]    bt_waddr;
  logic [CNT_W-1:0] bt_wdata;
  logic [BW-1:0]    bt_raddr;
  logic [CNT_W-1:0] bt_rdata;

  assign sum_next = sum_r + bt_rdata;

  always_comb begin
    unique case (cmd.bt_rd_sel)
      skil_pkg::BT_RD_BUCKET: bt_raddr = bucket_r;
      skil_pkg::BT_RD_PREV:   bt_raddr = bucket_r - BW'(1);
      default:                bt_raddr = sweep_r[BW-1:0];
    endcase
    bt_we    = 1'b0;
    bt_waddr = sweep_r[BW-1:0];
    bt_wdata = '0;
    if (cmd.clr_step) begin
      bt_we = 1'b1;
    end else if (cmd.fin_step && sweep_r != '0) begin
      bt_we    = 1'b1;
      bt_waddr = BW'(sweep_r - (BW+1)'(1));
      bt_wdata = sum_next;
    end else if (cmd.ld_commit) begin
      bt_we    = 1'b1;
      bt_waddr = bucket_r;
      bt_wdata = bt_rdata + CNT_W'(1);
    end
  end

  skil_ram #(.WIDTH(CNT_W), .DEPTH(NB)) u_bucket_ram (
    .clk     (clk),
    .wr_en   (bt_we),
    .wr_addr (bt_waddr),
    .wr_data (bt_wdata),
    .rd_addr (bt_raddr),
    .rd_data (bt_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_r <= '0;
    end else if (cmd.accept) begin
      sweep_r <= '0;
    end else if (cmd.clr_step || cmd.fin_step) begin
      sweep_r <= sweep_r + (BW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sum_r <= '0;
    end else if (cmd.fin_step && sweep_r != '0) begin
      sum_r <= sum_next;
    end
  end

  // Search bounds: lo_r is the first candidate, hi_r is one past the last.
  logic [CNT_W-1:0] end_r;
  logic [CNT_W-1:0] lo_r;
  logic [CNT_W-1:0] hi_r;
  logic [CNT_W-1:0] mid_r;
  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] end_c;
  logic [CNT_W-1:0] beg_c;
  logic [CW-1:0]    ent_rdata;

  always_comb begin
    mid_sum = {1'b0, lo_r} + {1'b0, hi_r} - (CNT_W+1)'(1);
    mid     = mid_sum[CNT_W:1];
    end_c   = (end_r > count_r) ? count_r : end_r;
    beg_c   = (bucket_r == '0) ? '0 : bt_rdata;
    if (beg_c > end_c) beg_c = end_c;
  end

  always_ff @(posedge clk) begin
    if (cmd.q_latch_end) end_r <= bt_rdata;
    if (cmd.q_bounds) begin
      lo_r <= beg_c;
      hi_r <= end_c;
    end else if (cmd.srch_lo_up) begin
      lo_r <= mid_r + CNT_W'(1);
    end else if (cmd.srch_hi_down) begin
      hi_r <= mid_r;
    end
    if (cmd.srch_issue) mid_r <= mid;
  end

  skil_ram #(.WIDTH(CW), .DEPTH(ENTRY_DEPTH)) u_entry_ram (
    .clk     (clk),
    .wr_en   (cmd.ld_commit),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (code_r),
    .rd_addr (mid[AW-1:0]),
    .rd_data (ent_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count_r <= '0;
      last_r  <= '0;
      fin_r   <= 1'b0;
    end else if (cmd.clear_state) begin
      count_r <= '0;
      last_r  <= '0;
      fin_r   <= 1'b0;
    end else if (cmd.ld_commit) begin
      count_r <= count_r + CNT_W'(1);
      last_r  <= code_r;
    end else if (cmd.fin_done) begin
      fin_r <= 1'b1;
    end
  end

  // Pending result and output register.
  skil_pkg::status_code_t              pend_status;
  logic                                pend_found;
  logic [skil_pkg::ENTRY_INDEX_W-1:0]  pend_index;

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      pend_status <= cmd.res_status;
      pend_found  <= (cmd.res_idx == skil_pkg::IDX_MID);
      unique case (cmd.res_idx)
        skil_pkg::IDX_COUNT: pend_index <= skil_pkg::ENTRY_INDEX_W'(count_r);
        skil_pkg::IDX_MID:   pend_index <= skil_pkg::ENTRY_INDEX_W'(mid_r);
        default:             pend_index <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_push) begin
      out_status      <= pend_status;
      out_found       <= pend_found;
      out_entry_index <= pend_index;
    end
  end

  always_comb begin
    sts.cmd        = cmd_r;
    sts.res_last   = (res_cnt == RC_W'(RES_STEPS - 1));
    sts.sampled    = sampled;
    sts.finalized  = fin_r;
    sts.order_bad  = (count_r != '0) && (code_r <= last_r);
    sts.full       = (count_r >= CNT_W'(ENTRY_DEPTH));
    sts.sweep_last = (sweep_r[BW-1:0] == {BW{1'b1}});
    sts.fin_last   = sweep_r[BW];
    sts.srch_empty = !(lo_r < hi_r);
    sts.cmp_eq     = (ent_rdata == code_r);
    sts.cmp_gt     = (ent_rdata > code_r);
    sts.out_free   = !out_valid || out_ready;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_r <= CNT_W'(ENTRY_DEPTH))
    else $error("entry count exceeds the store depth");

  a_search_window: assert property (@(posedge clk) disable iff (rst)
    (cmd.srch_lo_up || cmd.srch_hi_down || cmd.q_bounds) |=> (lo_r <= hi_r))
    else $error("search window became inverted");
`endif

endmodule

// ----- hdl/skil_ctrl.sv -----
// Controller state machine of the k-mer index: sequences clear, load, finalize and query.
// Depends on skil_pkg.
`timescale 1ns / 1ps

module skil_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  skil_pkg::dp_sts_t sts,
  output skil_pkg::dp_cmd_t cmd
);

  skil_pkg::ctrl_state_t state;
  skil_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skil_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      skil_pkg::S_INIT:   if (sts.sweep_last) state_next = skil_pkg::S_IDLE;
      skil_pkg::S_IDLE:   if (in_valid) state_next = skil_pkg::S_RES;
      skil_pkg::S_RES:    if (sts.res_last) state_next = skil_pkg::S_DECIDE;
      skil_pkg::S_DECIDE: begin
        unique case (sts.cmd)
          skil_pkg::CMD_CLEAR: state_next = skil_pkg::S_CLR;
          skil_pkg::CMD_LOAD: begin
            if (sts.finalized || !sts.sampled || sts.order_bad || sts.full) begin
              state_next = skil_pkg::S_RESP;
            end else begin
              state_next = skil_pkg::S_LD_RD;
            end
          end
          skil_pkg::CMD_FINALIZE: begin
            state_next = sts.finalized ? skil_pkg::S_RESP : skil_pkg::S_FIN;
          end
          default: begin
            if (!sts.finalized || !sts.sampled) begin
              state_next = skil_pkg::S_RESP;
            end else begin
              state_next = skil_pkg::S_Q_END;
            end
          end
        endcase
      end
      skil_pkg::S_CLR:    if (sts.sweep_last) state_next = skil_pkg::S_RESP;
      skil_pkg::S_FIN:    if (sts.fin_last) state_next = skil_pkg::S_RESP;
      skil_pkg::S_LD_RD:  state_next = skil_pkg::S_LD_WR;
      skil_pkg::S_LD_WR:  state_next = skil_pkg::S_RESP;
      skil_pkg::S_Q_END:  state_next = skil_pkg::S_Q_BEG;
      skil_pkg::S_Q_BEG:  state_next = skil_pkg::S_Q_BND;
      skil_pkg::S_Q_BND:  state_next = skil_pkg::S_S_ADDR;
      skil_pkg::S_S_ADDR: begin
        state_next = sts.srch_empty ? skil_pkg::S_RESP : skil_pkg::S_S_CMP;
      end
      skil_pkg::S_S_CMP:  state_next = sts.cmp_eq ? skil_pkg::S_RESP : skil_pkg::S_S_ADDR;
      skil_pkg::S_RESP:   if (sts.out_free) state_next = skil_pkg::S_IDLE;
      default:            state_next = skil_pkg::S_INIT;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.bt_rd_sel = skil_pkg::BT_RD_SWEEP;
    cmd.res_idx   = skil_pkg::IDX_ZERO;
    cmd.res_status = skil_pkg::STAT_OK;
    in_ready      = 1'b0;
    unique case (state)
      skil_pkg::S_INIT: begin
        cmd.clr_step    = 1'b1;
        cmd.clear_state = sts.sweep_last;
      end
      skil_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      skil_pkg::S_RES: cmd.res_step = 1'b1;
      skil_pkg::S_DECIDE: begin
        unique case (sts.cmd)
          skil_pkg::CMD_CLEAR: ;
          skil_pkg::CMD_LOAD: begin
            cmd.res_set = 1'b1;
            priority if (sts.finalized) cmd.res_status = skil_pkg::STAT_ORDER;
            else if (!sts.sampled)      cmd.res_status = skil_pkg::STAT_UNSAMPLED;
            else if (sts.order_bad)     cmd.res_status = skil_pkg::STAT_ORDER;
            else if (sts.full)          cmd.res_status = skil_pkg::STAT_FULL;
            else                        cmd.res_set = 1'b0;
          end
          skil_pkg::CMD_FINALIZE: cmd.res_set = sts.finalized;
          default: begin
            cmd.res_set = 1'b1;
            priority if (!sts.finalized) cmd.res_status = skil_pkg::STAT_NOT_FIN;
            else if (!sts.sampled)       cmd.res_status = skil_pkg::STAT_UNSAMPLED;
            else                         cmd.res_set = 1'b0;
          end
        endcase
      end
      skil_pkg::S_CLR: begin
        cmd.clr_step    = 1'b1;
        cmd.clear_state = sts.sweep_last;
        cmd.res_set     = sts.sweep_last;
      end
      skil_pkg::S_FIN: begin
        cmd.fin_step = 1'b1;
        cmd.fin_done = sts.fin_last;
        cmd.res_set  = sts.fin_last;
      end
      skil_pkg::S_LD_RD: cmd.bt_rd_sel = skil_pkg::BT_RD_BUCKET;
      skil_pkg::S_LD_WR: begin
        cmd.ld_commit = 1'b1;
        cmd.res_set   = 1'b1;
        cmd.res_idx   = skil_pkg::IDX_COUNT;
      end
      skil_pkg::S_Q_END: cmd.bt_rd_sel = skil_pkg::BT_RD_BUCKET;
      skil_pkg::S_Q_BEG: begin
        cmd.bt_rd_sel   = skil_pkg::BT_RD_PREV;
        cmd.q_latch_end = 1'b1;
      end
      skil_pkg::S_Q_BND: cmd.q_bounds = 1'b1;
      skil_pkg::S_S_ADDR: begin
        if (sts.srch_empty) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = skil_pkg::STAT_MISS;
        end else begin
          cmd.srch_issue = 1'b1;
        end
      end
      skil_pkg::S_S_CMP: begin
        priority if (sts.cmp_eq) begin
          cmd.res_set = 1'b1;
          cmd.res_idx = skil_pkg::IDX_MID;
        end else if (sts.cmp_gt) begin
          cmd.srch_hi_down = 1'b1;
        end else begin
          cmd.srch_lo_up = 1'b1;
        end
      end
      skil_pkg::S_RESP: cmd.out_push = sts.out_free;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_push |-> sts.out_free)
    else $error("result pushed into an occupied output register");

  a_fin_to_resp: assert property (@(posedge clk) disable iff (rst)
    (state == skil_pkg::S_FIN && sts.fin_last) |=> (state == skil_pkg::S_RESP))
    else $error("finalize sweep did not hand over to the response");
`endif

endmodule

// ----- hdl/sampled_kmer_index_lookup_core.sv -----
// Transactions are handled one at a time; the residue unit takes 4 bits a cycle and the
// binary search issues one entry read per search step.
// Reset: synchronous and active high; afterwards a clearing pass over all 4^MAX_PREFIX_BASES
// bucket entries (65536 by default) zeroes the bucket table while no input transaction is taken.
// Depends on skil_pkg, skil_ctrl, skil_dp and skil_ram.
`timescale 1ns / 1ps

module sampled_kmer_index_lookup_core #(
  parameter int ENTRY_DEPTH      = skil_pkg::ENTRY_DEPTH,
  parameter int MAX_PREFIX_BASES = skil_pkg::MAX_PREFIX_BASES,
  parameter int MAX_KMER_BASES   = skil_pkg::MAX_KMER_BASES
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel; register 0 is kmer_length, register 1 is prefix_length.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [skil_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [skil_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [61:0] kmer_code, [63:62] zero
  input  logic [1:0]  s_tuser,   // [1:0] command
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] entry_index
  output logic [3:0]  m_tuser    // [2:0] status, [3] found
);

  skil_pkg::dp_cmd_t      cmd;
  skil_pkg::dp_sts_t      sts;
  skil_pkg::status_code_t out_status;
  logic                   out_found;

  // Configuration writes are always taken; the user, not the block, makes them only while idle.
  assign cfg_ready = 1'b1;

  skil_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the result in an output register, so a finished transaction can
  // wait on the result side while the next input transaction is already accepted.
  skil_dp #(
    .ENTRY_DEPTH      (ENTRY_DEPTH),
    .MAX_PREFIX_BASES (MAX_PREFIX_BASES),
    .MAX_KMER_BASES   (MAX_KMER_BASES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_command      (skil_pkg::cmd_code_t'(s_tuser)),
    .in_kmer_code    (s_tdata[skil_pkg::KMER_CODE_W-1:0]),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_status      (out_status),
    .out_found       (out_found),
    .out_entry_index (m_tdata)
  );

  assign m_tuser = {out_found, out_status};

endmodule
